[rtl/assert_macros.svh]
// Assertion macros used by the converter top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clk, disabled while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |-> (cons), msg)

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

[rtl/p2rgb_pkg.sv]
// Package with the constants, types and lookup tables of the pixel converter.
`timescale 1ns / 1ps

package p2rgb_pkg;

    // Sizes of the palette and of the frame.
    localparam int PAL_ENTRIES   = 256;
    localparam int PAL_AW        = $clog2(PAL_ENTRIES);
    localparam int MAX_DIMENSION = 4096;

    // Field widths.
    localparam int COLOR_W   = 8;
    localparam int PAL_VAL_W = 24;
    localparam int CNT_W     = 12;
    localparam int DIM_W     = 13;
    localparam int MODE_W    = 3;
    localparam int CFG_AW    = 2;
    localparam int CFG_DW    = 13;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 48;

    // Reset values of the configuration registers.
    localparam logic [MODE_W-1:0] MODE_RESET   = 3'd4;
    localparam logic [DIM_W-1:0]  WIDTH_RESET  = 13'd640;
    localparam logic [DIM_W-1:0]  HEIGHT_RESET = 13'd480;

    // Source pixel formats; BGR24 and other codes convert as XRGB32.
    typedef enum logic [MODE_W-1:0] {
        CM_PALETTE = 3'd0,
        CM_RGB555  = 3'd1,
        CM_RGB565  = 3'd2,
        CM_BGR24   = 3'd3,
        CM_XRGB32  = 3'd4
    } color_mode_t;

    // Configuration register indexes.
    typedef enum logic [CFG_AW-1:0] {
        CFG_COLOR_MODE   = 2'd0,
        CFG_FRAME_WIDTH  = 2'd1,
        CFG_FRAME_HEIGHT = 2'd2
    } cfg_index_t;

    // Request kinds carried in tuser.
    localparam logic REQ_PIXEL   = 1'b0;
    localparam logic REQ_PAL_WR  = 1'b1;

    // Channel expansion tables: c * 255 / (2^n - 1), truncated.
    typedef logic [COLOR_W-1:0] lut32_t [32];
    typedef logic [COLOR_W-1:0] lut64_t [64];

    function automatic lut32_t build_widen5();
        lut32_t t;
        for (int i = 0; i < 32; i++)
        begin
            t[i] = COLOR_W'((i * 255) / 31);
        end
        return t;
    endfunction

    function automatic lut64_t build_widen6();
        lut64_t t;
        for (int i = 0; i < 64; i++)
        begin
            t[i] = COLOR_W'((i * 255) / 63);
        end
        return t;
    endfunction

    localparam lut32_t WIDEN5_LUT = build_widen5();
    localparam lut64_t WIDEN6_LUT = build_widen6();

    // A dimension of zero acts as one, any value above the maximum as the maximum.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > DIM_W'(MAX_DIMENSION))
        begin
            r = DIM_W'(MAX_DIMENSION);
        end
        return r;
    endfunction

endpackage

[rtl/pixel_to_rgb888_converter.sv]
// Top level of the pixel format to RGB888 converter.
//
//   Channel   Direction  Signals                        Content
//   s_axis    in         tvalid tready tdata tuser      pixel or palette write request
//   m_axis    out        tvalid tready tdata tlast      RGB888 pixel with placement
//   cfg       in         cfg_wr_en cfg_addr cfg_wdata   color mode, frame size
//
// One request is taken every clock cycle while s_axis_tready is high; a pixel
// result passes the palette RAM read, then conversion into the output register.
// A palette write produces no result. The two stages are an elastic pipeline:
// s_axis_tready drops only when both stages are full and m_axis_tready is low.
// Reset clears the palette through per-entry valid bits, with no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pixel_to_rgb888_converter (
    input  logic                                clk,
    input  logic                                rst_n,
    // Slave stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // pixel_word[31:0], palette_index[39:32], palette_value[63:40]
    input  logic [p2rgb_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // req_type[0]
    input  logic                                s_axis_tuser,
    // Master stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // red[7:0], green[15:8], blue[23:16], dest_row[35:24], dest_col[47:36]
    output logic [p2rgb_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // frame_end
    output logic                                m_axis_tlast,
    // Configuration write port
    input  logic                                cfg_wr_en,
    input  logic [p2rgb_pkg::CFG_AW-1:0]        cfg_addr,
    input  logic [p2rgb_pkg::CFG_DW-1:0]        cfg_wdata
);

    import p2rgb_pkg::*;

    // Configuration registers
    logic [MODE_W-1:0]    color_mode_reg;
    logic [DIM_W-1:0]     frame_width_reg;
    logic [DIM_W-1:0]     frame_height_reg;

    // Position counters
    logic [CNT_W-1:0]     col_reg, col_next;
    logic [CNT_W-1:0]     row_reg, row_next;

    // Palette valid bits
    logic [PAL_ENTRIES-1:0] pal_vld_reg;

    // Stage 1: request after palette read
    logic                 s1_valid_reg, s1_valid_next;
    logic [PAL_VAL_W-1:0] s1_px_reg;
    logic                 s1_pal_ok_reg;
    logic [CNT_W-1:0]     s1_row_reg;
    logic [CNT_W-1:0]     s1_col_reg;
    logic                 s1_last_reg;

    // Stage 2: output register
    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg;
    logic                 m_last_reg;

    // Request fields and handshake
    logic [31:0]          in_px;
    logic [7:0]           in_idx;
    logic [PAL_VAL_W-1:0] in_val;
    logic                 in_acc;
    logic                 pix_acc;
    logic                 pal_wr;
    logic                 rd_in_range;
    logic                 adv;

    // Placement
    logic [DIM_W-1:0]     w_dim;
    logic [DIM_W-1:0]     h_dim;
    logic [CNT_W-1:0]     col_eff;
    logic [CNT_W-1:0]     row_eff;
    logic                 col_last;
    logic                 row_last;
    logic [CNT_W-1:0]     dest_row;

    // Conversion
    logic [PAL_VAL_W-1:0] pal_rdata;
    logic [PAL_VAL_W-1:0] pal_entry;
    logic [COLOR_W-1:0]   red, green, blue;

    assign in_px  = s_axis_tdata[31:0];
    assign in_idx = s_axis_tdata[39:32];
    assign in_val = s_axis_tdata[63:40];

    // Handshake: stage 1 moves on when the output register is free or drained.
    assign adv           = s1_valid_reg && (!m_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign pix_acc       = in_acc && (s_axis_tuser == REQ_PIXEL);
    assign pal_wr        = in_acc && (s_axis_tuser == REQ_PAL_WR)
                           && ({1'b0, in_idx} < 9'(PAL_ENTRIES));
    assign rd_in_range   = {1'b0, in_px[7:0]} < 9'(PAL_ENTRIES);

    // Configuration registers; writes beyond the register list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_mode_reg   <= MODE_RESET;
            frame_width_reg  <= WIDTH_RESET;
            frame_height_reg <= HEIGHT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                CFG_COLOR_MODE:   color_mode_reg   <= cfg_wdata[MODE_W-1:0];
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[DIM_W-1:0];
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[DIM_W-1:0];
                default:          ;
            endcase
        end
    end

    // Effective frame size and current position, restarting any counter
    // that lies outside a shrunken frame.
    always_comb
    begin
        w_dim    = clamp_dim(frame_width_reg);
        h_dim    = clamp_dim(frame_height_reg);
        col_eff  = ({1'b0, col_reg} >= w_dim) ? '0 : col_reg;
        row_eff  = ({1'b0, row_reg} >= h_dim) ? '0 : row_reg;
        col_last = ({1'b0, col_eff} == (w_dim - DIM_W'(1)));
        row_last = ({1'b0, row_eff} == (h_dim - DIM_W'(1)));
        dest_row = CNT_W'(h_dim - DIM_W'(1) - {1'b0, row_eff});

        col_next = col_reg;
        row_next = row_reg;
        if (pix_acc)
        begin
            col_next = col_last ? '0 : col_eff + CNT_W'(1);
            row_next = row_eff;
            if (col_last)
            begin
                row_next = row_last ? '0 : row_eff + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Palette storage; an entry never written reads as black.
    p2rgb_ram #(
        .WIDTH (PAL_VAL_W),
        .DEPTH (PAL_ENTRIES)
    ) u_palette (
        .clk     (clk),
        .wr_en   (pal_wr),
        .wr_addr (in_idx[PAL_AW-1:0]),
        .wr_data (in_val),
        .rd_en   (pix_acc),
        .rd_addr (in_px[PAL_AW-1:0]),
        .rd_data (pal_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pal_vld_reg <= '0;
        end
        else if (pal_wr)
        begin
            pal_vld_reg[in_idx[PAL_AW-1:0]] <= 1'b1;
        end
    end

    // Stage 1 control
    assign s1_valid_next = pix_acc ? 1'b1 : (adv ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Stage 1 payload, captured with the palette read
    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            s1_px_reg     <= in_px[PAL_VAL_W-1:0];
            s1_pal_ok_reg <= rd_in_range && pal_vld_reg[in_px[PAL_AW-1:0]];
            s1_row_reg    <= dest_row;
            s1_col_reg    <= col_eff;
            s1_last_reg   <= col_last && row_last;
        end
    end

    // Color conversion for the current mode
    assign pal_entry = s1_pal_ok_reg ? pal_rdata : '0;

    always_comb
    begin
        case (color_mode_reg)
            CM_PALETTE:
            begin
                red   = pal_entry[7:0];
                green = pal_entry[15:8];
                blue  = pal_entry[23:16];
            end
            CM_RGB555:
            begin
                red   = WIDEN5_LUT[s1_px_reg[14:10]];
                green = WIDEN5_LUT[s1_px_reg[9:5]];
                blue  = WIDEN5_LUT[s1_px_reg[4:0]];
            end
            CM_RGB565:
            begin
                red   = WIDEN5_LUT[s1_px_reg[15:11]];
                green = WIDEN6_LUT[s1_px_reg[10:5]];
                blue  = WIDEN5_LUT[s1_px_reg[4:0]];
            end
            default:
            begin
                red   = s1_px_reg[23:16];
                green = s1_px_reg[15:8];
                blue  = s1_px_reg[7:0];
            end
        endcase
    end

    // Output register control
    assign m_valid_next = adv ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_data_reg <= {s1_col_reg, s1_row_reg, blue, green, red};
            m_last_reg <= s1_last_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

    // Checks
    logic [DIM_W-1:0] out_col_ext;
    logic             out_at_corner;

    assign out_col_ext   = {1'b0, m_data_reg[47:36]};
    assign out_at_corner = (m_data_reg[35:24] == '0)
                           && (out_col_ext == (w_dim - DIM_W'(1)));

    `ASSERT_IMPLY(a_stall_only_when_full, !s_axis_tready,
        s1_valid_reg && m_valid_reg && !m_axis_tready,
        "input stalled while the pipeline has room")
    `ASSERT_IMPLY(a_col_in_frame, m_valid_reg, out_col_ext < w_dim,
        "destination column outside the frame")
    `ASSERT_IMPLY(a_frame_end_corner, m_valid_reg && m_last_reg, out_at_corner,
        "frame end flagged away from the last pixel")
    `ASSERT_NEXT(a_pixel_enters_stage1, pix_acc, s1_valid_reg,
        "accepted pixel missing from stage 1")

endmodule

[rtl/p2rgb_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module p2rgb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port, and a read port that holds its data while not enabled.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
